>>> rtl/lru_key_value_cache_core_assert.svh
// Assertion macros used by the cache core RTL.
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKVC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lkvc_pkg.sv
// Types and constants shared by the cache core and its entry cells.
package lkvc_pkg;

	localparam int WORD_W = 32;
	localparam int CAP_W  = 5;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CAP_W-1:0] cap_t;

	// One stored pair together with its occupancy flag.
	typedef struct packed {
		logic  valid;
		word_t key;
		word_t value;
	} entry_t;

	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	localparam word_t MISS_VALUE = '1;
	localparam cap_t  CAP_RESET  = cap_t'(16);

endpackage

>>> rtl/lkvc_cell.sv
// One entry of the recency-ordered chain: holds a pair and compares it to the probe key.
module lkvc_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  lkvc_pkg::entry_t prev,
	input  lkvc_pkg::word_t  probe_key,
	output lkvc_pkg::entry_t entry,
	output logic             match
);
	import lkvc_pkg::*;

	logic  valid_q;
	word_t key_q;
	word_t value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end

	assign entry = '{valid: valid_q, key: key_q, value: value_q};
	assign match = valid_q && (key_q == probe_key);

endmodule

>>> rtl/lru_key_value_cache_core.sv
// Fully associative key-value cache with LRU replacement, built as a recency-ordered chain.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  command  | start / busy           | kind, key, value
//  result   | done (one-cycle pulse) | hit, read_value
//  config   | cfg_we                 | cfg_wdata (capacity)
//
// Busy stays low, so a command may be issued every cycle.
// A get produces its result on done in the cycle after its transfer; a put produces none.
// The cost of a cycle is the parallel key compare across all cells plus the shift select.
// Reset clears all occupancy flags and the fill count at once; no clearing pass is needed.
// The result channel has no back-pressure.
module lru_key_value_cache_core #(
	parameter int ENTRIES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic            kind,
	input  lkvc_pkg::word_t key,
	input  lkvc_pkg::word_t value,
	output logic            done,
	output logic            hit,
	output lkvc_pkg::word_t read_value,
	input  logic            cfg_we,
	input  lkvc_pkg::cap_t  cfg_wdata
);
	import lkvc_pkg::*;

	`include "lru_key_value_cache_core_assert.svh"

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Position in the chain is recency: cell 0 holds the most recent entry.
	entry_t             cell_entry [ENTRIES];
	entry_t             cell_prev  [ENTRIES];
	logic [ENTRIES-1:0] cell_match;
	logic [ENTRIES-1:0] cell_valid;
	logic [ENTRIES-1:0] match_at_or_above;
	logic [ENTRIES-1:0] cell_shift;

	cap_t             capacity_q;
	logic [CNT_W-1:0] count_q;

	logic             accept;
	logic             is_put;
	logic             hit_any;
	logic             full;
	word_t            hit_value;
	entry_t           head;
	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] eff_cap;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign is_put = (kind == KIND_PUT);

	genvar gi;
	generate
		for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
			lkvc_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.shift     (cell_shift[gi]),
				.prev      (cell_prev[gi]),
				.probe_key (key),
				.entry     (cell_entry[gi]),
				.match     (cell_match[gi])
			);

			assign cell_valid[gi]        = cell_entry[gi].valid;
			assign match_at_or_above[gi] = |cell_match[ENTRIES-1:gi];

			if (gi == 0) begin : g_head
				assign cell_prev[gi] = head;
				// A new key always enters here; cell 0 is free or holds a valid entry.
				assign cell_shift[gi] = accept && (hit_any ? match_at_or_above[gi] : is_put);
			end else begin : g_body
				assign cell_prev[gi] = cell_entry[gi-1];
				// On a put miss the chain shifts through the oldest entry when full,
				// or one cell further, into the first free cell, otherwise.
				assign cell_shift[gi] = accept && (hit_any ? match_at_or_above[gi] :
					(is_put && (full ? cell_valid[gi] : cell_valid[gi-1])));
			end
		end
	endgenerate

	assign hit_any = |cell_match;

	// Keys are unique among valid cells, so at most one term is nonzero.
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (cell_match[i]) begin
				hit_value = hit_value | cell_entry[i].value;
			end
		end
	end

	assign head = '{valid: 1'b1, key: key, value: (is_put ? value : hit_value)};

	// Capacity of zero behaves as one; anything above the cell count saturates.
	assign cap_ext = CMP_W'(capacity_q);
	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end
	assign full = (CMP_W'(count_q) >= eff_cap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			count_q    <= '0;
			done       <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (accept && is_put && !hit_any && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
			done <= accept && !is_put;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_put) begin
			hit        <= hit_any;
			read_value <= hit_any ? hit_value : MISS_VALUE;
		end
	end

	`LKVC_ASSERT_SAME(a_unique_match, 1'b1, $onehot0(cell_match),
		"more than one cell matched the key")
	`LKVC_ASSERT_SAME(a_count_tracks_valid, 1'b1, $countones(cell_valid) == int'(count_q),
		"fill count disagrees with the valid cells")
	`LKVC_ASSERT_SAME(a_valid_prefix, 1'b1, (cell_valid & (cell_valid + 1'b1)) == '0,
		"valid cells do not form a contiguous run from the head")
	`LKVC_ASSERT_NEXT(a_done_after_get, accept && (kind == KIND_GET), done,
		"a get transfer produced no result")

endmodule

>>> dv/tb_lru_key_value_cache_core.sv
// Self-checking testbench for the LRU key-value cache core: commands, capacity changes, read checks.
module tb_lru_key_value_cache_core;
	timeunit 1ns;
	timeprecision 1ps;

	import lkvc_pkg::*;

	localparam int ENTRIES = 16;

	typedef struct {
		logic  hit;
		word_t value;
	} read_t;

	// Keeps its own copy of the cache contents and recency order, and checks every read.
	class lru_read_scoreboard;
		word_t      keys[ENTRIES];
		word_t      vals[ENTRIES];
		bit         valid[ENTRIES];
		bit [3:0]   rank[ENTRIES];
		bit [4:0]   occupied;
		cap_t       capacity;
		read_t      expected_reads[$];
		int         faults;
		int         gets;
		int         hits;
		int         puts;
		int         evictions;
		int         cap_writes;

		function new();
			foreach (valid[i]) begin
				valid[i] = 1'b0;
				rank[i]  = '0;
			end
			occupied   = '0;
			capacity   = CAP_RESET;
			faults     = 0;
			gets       = 0;
			hits       = 0;
			puts       = 0;
			evictions  = 0;
			cap_writes = 0;
		endfunction

		function void write_capacity(cap_t c);
			capacity = c;
			cap_writes++;
		endfunction

		function int lookup(word_t k);
			foreach (valid[i])
				if (valid[i] && keys[i] == k)
					return i;
			return -1;
		endfunction

		// The entry becomes most recent; entries younger than it age by one.
		function void promote(int idx);
			bit [3:0] r;
			r = rank[idx];
			foreach (valid[i])
				if (valid[i] && i != idx && rank[i] < r)
					rank[i]++;
			rank[idx] = '0;
		endfunction

		function void note_command(logic k, word_t ky, word_t v);
			int       found;
			int       slot;
			bit [4:0] limit;
			read_t    rd;
			found = lookup(ky);
			if (k == KIND_GET) begin
				gets++;
				if (found >= 0) begin
					promote(found);
					rd.hit   = 1'b1;
					rd.value = vals[found];
				end else begin
					rd.hit   = 1'b0;
					rd.value = MISS_VALUE;
				end
				expected_reads.push_back(rd);
				return;
			end
			puts++;
			if (found >= 0) begin
				vals[found] = v;
				promote(found);
				return;
			end
			limit = capacity;
			if (limit == 0)
				limit = 5'd1;
			if (limit > ENTRIES)
				limit = 5'(ENTRIES);
			if (occupied >= limit) begin
				slot = -1;
				foreach (valid[i])
					if (valid[i] && (slot < 0 || rank[i] >= rank[slot]))
						slot = i;
				keys[slot] = ky;
				vals[slot] = v;
				promote(slot);
				evictions++;
				return;
			end
			slot = -1;
			foreach (valid[i])
				if (!valid[i] && slot < 0)
					slot = i;
			foreach (valid[i])
				if (valid[i])
					rank[i]++;
			valid[slot] = 1'b1;
			keys[slot]  = ky;
			vals[slot]  = v;
			rank[slot]  = '0;
			occupied++;
		endfunction

		function void check_read(logic h, word_t v);
			read_t rd;
			if (expected_reads.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("ERROR: unexpected read result hit=%0b value=%08h", h, v);
				return;
			end
			rd = expected_reads.pop_front();
			if (h === 1'b1)
				hits++;
			if (h !== rd.hit || v !== rd.value) begin
				faults++;
				if (faults <= 10)
					$display("ERROR: read mismatch: expected hit=%0b value=%08h, got hit=%0b value=%08h",
						rd.hit, rd.value, h, v);
			end
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy;
	logic  kind = KIND_GET;
	word_t key = '0;
	word_t value = '0;
	logic  done;
	logic  hit;
	word_t read_value;
	logic  cfg_we = 1'b0;
	cap_t  cfg_wdata = '0;

	lru_read_scoreboard sb = new();
	bit no_idle;

	lru_key_value_cache_core #(.ENTRIES(ENTRIES)) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.key        (key),
		.value      (value),
		.done       (done),
		.hit        (hit),
		.read_value (read_value),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	// Everything is sampled here at the edge, so the driver's ordering does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_read(hit, read_value);
			if (cfg_we)
				sb.write_capacity(cfg_wdata);
			if (start && !busy)
				sb.note_command(kind, key, value);
		end
	end

	task automatic issue(input logic k, input word_t ky, input word_t v);
		start <= 1'b1;
		kind  <= k;
		key   <= ky;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			start <= 1'b0;
			kind  <= 1'($urandom_range(0, 1));
			key   <= $urandom;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// The capacity is only written once all reads are back and the last put has settled.
	task automatic set_capacity(input cap_t c);
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_reads.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	function automatic word_t odd_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Keys come mostly from a small pool so that gets hit and puts update or evict.
	task automatic run_phase(input int n_items, input int pool_size);
		word_t pool[$];
		word_t ky;
		word_t v;
		repeat (pool_size)
			pool.push_back(($urandom_range(0, 7) == 0) ? odd_word() : word_t'($urandom));
		for (int i = 0; i < n_items; i++) begin
			if (i % 20 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 85)
				ky = pool[$urandom_range(0, pool.size() - 1)];
			else
				ky = odd_word();
			v = ($urandom_range(0, 9) == 0) ? odd_word() : word_t'($urandom);
			issue($urandom_range(0, 1) ? KIND_PUT : KIND_GET, ky, v);
			pause(pick_gap());
		end
	endtask

	initial begin
		cap_t caps[10];
		int   eff;
		caps = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd8, 5'd16, 5'd2, 5'd17, 5'd12};
		no_idle = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty miss, extreme keys and values, update of a present key.
		issue(KIND_GET, 32'h0000_0000, 32'h5A5A_5A5A);
		issue(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		issue(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		pause(2);
		issue(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
		issue(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(KIND_GET, 32'h8000_0000, 32'h0000_0000);
		issue(KIND_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		issue(KIND_GET, 32'h0000_0000, 32'h1234_0000);
		issue(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		issue(KIND_PUT, 32'h0000_0000, 32'h1234_5678);
		issue(KIND_GET, 32'h0000_0000, 32'h0000_0000);
		issue(KIND_GET, 32'h0000_0005, 32'hFFFF_FFFF);

		// Lowering the capacity below the fill count: new keys replace the oldest entries.
		set_capacity(5'd2);
		issue(KIND_PUT, 32'h0000_0100, 32'hCAFE_0001);
		issue(KIND_GET, 32'h8000_0000, 32'h0000_0000);
		issue(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		issue(KIND_PUT, 32'h0000_0200, 32'hCAFE_0002);
		issue(KIND_GET, 32'h0000_0100, 32'h0000_0000);
		issue(KIND_GET, 32'h0000_0000, 32'h0000_0000);
		pause(1);

		foreach (caps[p]) begin
			set_capacity(caps[p]);
			eff = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES) ? ENTRIES : caps[p];
			run_phase(83, eff + $urandom_range(1, eff / 2 + 2));
		end

		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_reads.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Covered %0d gets (%0d hits) and %0d puts (%0d evictions).",
			sb.gets, sb.hits, sb.puts, sb.evictions);
		$display("Capacity was written %0d times; %0d mismatches seen.", sb.cap_writes, sb.faults);
		if (sb.faults == 0 && sb.expected_reads.size() == 0) begin
			$display("lru_key_value_cache_core verification clean");
		end else begin
			$display("lru_key_value_cache_core verification failed");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Timeout with %0d reads still outstanding.", sb.expected_reads.size());
		$display("lru_key_value_cache_core verification failed");
		$finish;
	end

endmodule
